// File: rtl/pfba_pkg.sv
// shared codes and controller/datapath interface types for the page frame allocator
package pfba_pkg;

	localparam logic [2:0] CMD_ALLOC = 3'd0;
	localparam logic [2:0] CMD_FREE  = 3'd1;
	localparam logic [2:0] CMD_MARK  = 3'd2;
	localparam logic [2:0] CMD_QUERY = 3'd3;
	localparam logic [2:0] CMD_INIT  = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NO_RUN = 2'd1;
	localparam logic [1:0] ST_ZERO   = 2'd2;
	localparam logic [1:0] ST_RANGE  = 2'd3;

	localparam logic [1:0] MD_SCAN  = 2'd0;
	localparam logic [1:0] MD_WRITE = 2'd1;
	localparam logic [1:0] MD_READ  = 2'd2;

	localparam logic CFG_PAGE_COUNT = 1'b0;
	localparam logic CFG_RESERVED   = 1'b1;

	localparam logic [10:0] PAGE_COUNT_RST = 11'd1024;

	typedef struct packed {
		logic take;
		logic setup;
		logic rd;
		logic ld;
		logic step;
		logic wb;
		logic mark_setup;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic early;
		logic empty;
		logic last;
		logic wrap;
		logic done;
		logic found;
		logic scan;
	} dp_stat_t;

endpackage

// File: rtl/pfba_ram.sv
// generic single-write, single-read ram with registered read data
module pfba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/pfba_datapath.sv
// busy map storage, walk counters, run search and result registers
module pfba_datapath #(
	parameter int MAX_PAGES = 1024,
	parameter int WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pfba_pkg::dp_cmd_t   c,
	output pfba_pkg::dp_stat_t  s,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [10:0]         cfg_data,
	input  logic [2:0]          cmd,
	input  logic [19:0]         page_index,
	input  logic [10:0]         count,
	input  logic                busy_req,
	output logic [1:0]          status,
	output logic [9:0]          start_page,
	output logic                bit_value
);

	localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int PW = $clog2(MAX_PAGES + 1);
	localparam int AW = $clog2(MAP_WORDS > 1 ? MAP_WORDS : 2);
	localparam int BW = $clog2(WORD_BITS);

	logic [2:0]  cmd_q;
	logic [19:0] idx_q;
	logic [10:0] cnt_q;
	logic        req_q;
	logic [10:0] page_count_q;
	logic [10:0] reserved_q;

	logic [PW-1:0] cur_q, end_q, first_q;
	logic [AW-1:0] wa_q, first_wa_q;
	logic [BW-1:0] bo_q, first_bo_q;
	logic [1:0]    mode_q;
	logic          val_q;
	logic [WORD_BITS-1:0] buf_q;
	logic [MAP_WORDS-1:0] vld_q;
	logic          rd_vld_q;
	logic [10:0]   run_q;
	logic          found_q, done_q, rbit_q, early_q;
	logic [1:0]    est_q;
	logic [WORD_BITS-1:0] rdata;

	logic [PW-1:0] pc, idx_p, fend, res_lim, s_start, s_end, nxt;
	logic [31:0]   fsum;
	logic          idx_ok, early, s_val, hit, cur_bit;
	logic [1:0]    early_st, s_mode;

	// effective page count and clipped limits
	always_comb begin
		pc = (32'(page_count_q) > 32'(MAX_PAGES)) ? PW'(MAX_PAGES) : PW'(page_count_q);
		idx_ok = 32'(idx_q) < 32'(pc);
		idx_p = PW'(idx_q);
		fsum = 32'(idx_q) + 32'(cnt_q);
		fend = (fsum > 32'(pc)) ? pc : PW'(fsum);
		res_lim = (32'(reserved_q) < 32'(pc)) ? PW'(reserved_q) : pc;
	end

	always_comb begin
		early = 1'b0;
		early_st = pfba_pkg::ST_OK;
		s_start = '0;
		s_end = '0;
		s_mode = pfba_pkg::MD_READ;
		s_val = 1'b0;
		case (cmd_q)
			pfba_pkg::CMD_ALLOC: begin
				if (cnt_q == 11'd0) begin
					early = 1'b1;
					early_st = pfba_pkg::ST_ZERO;
				end else begin
					s_end = pc;
					s_mode = pfba_pkg::MD_SCAN;
				end
			end
			pfba_pkg::CMD_FREE: begin
				if (cnt_q == 11'd0) begin
					early = 1'b1;
					early_st = pfba_pkg::ST_ZERO;
				end else if (!idx_ok) begin
					early = 1'b1;
					early_st = pfba_pkg::ST_RANGE;
				end else begin
					s_start = idx_p;
					s_end = fend;
					s_mode = pfba_pkg::MD_WRITE;
				end
			end
			pfba_pkg::CMD_MARK: begin
				if (!idx_ok) begin
					early = 1'b1;
					early_st = pfba_pkg::ST_RANGE;
				end else begin
					s_start = idx_p;
					s_end = idx_p + PW'(1);
					s_mode = pfba_pkg::MD_WRITE;
					s_val = req_q;
				end
			end
			pfba_pkg::CMD_QUERY: begin
				if (!idx_ok) begin
					early = 1'b1;
					early_st = pfba_pkg::ST_RANGE;
				end else begin
					s_start = idx_p;
					s_end = idx_p + PW'(1);
					s_mode = pfba_pkg::MD_READ;
				end
			end
			pfba_pkg::CMD_INIT: begin
				s_end = res_lim;
				s_mode = pfba_pkg::MD_WRITE;
				s_val = 1'b1;
			end
			default: begin
				early = 1'b1;
			end
		endcase
	end

	always_comb begin
		cur_bit = buf_q[bo_q];
		nxt = cur_q + PW'(1);
		hit = (mode_q == pfba_pkg::MD_SCAN) && !cur_bit &&
			((12'(run_q) + 12'd1) == 12'(cnt_q));
		s.early = early;
		s.empty = s_start >= s_end;
		s.last = (nxt == end_q) || hit;
		s.wrap = bo_q == BW'(WORD_BITS - 1);
		s.done = done_q;
		s.found = found_q;
		s.scan = mode_q == pfba_pkg::MD_SCAN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= pfba_pkg::PAGE_COUNT_RST;
			reserved_q <= '0;
			vld_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == pfba_pkg::CFG_PAGE_COUNT) begin
					page_count_q <= cfg_data;
				end else begin
					reserved_q <= cfg_data;
				end
			end
			// init forgets every word, later reads see zero
			if (c.setup && cmd_q == pfba_pkg::CMD_INIT) begin
				vld_q <= '0;
			end
			if (c.wb && mode_q == pfba_pkg::MD_WRITE) begin
				vld_q[wa_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (c.take) begin
			cmd_q <= cmd;
			idx_q <= page_index;
			cnt_q <= count;
			req_q <= busy_req;
		end
		if (c.setup) begin
			early_q <= early;
			est_q <= early_st;
			cur_q <= s_start;
			end_q <= s_end;
			wa_q <= AW'(s_start / WORD_BITS);
			bo_q <= BW'(s_start % WORD_BITS);
			mode_q <= s_mode;
			val_q <= s_val;
			run_q <= '0;
			found_q <= 1'b0;
			done_q <= 1'b0;
			rbit_q <= 1'b0;
		end
		if (c.mark_setup) begin
			cur_q <= first_q;
			end_q <= first_q + PW'(cnt_q);
			wa_q <= first_wa_q;
			bo_q <= first_bo_q;
			mode_q <= pfba_pkg::MD_WRITE;
			val_q <= 1'b1;
			done_q <= 1'b0;
		end
		if (c.rd) begin
			rd_vld_q <= vld_q[wa_q];
		end
		if (c.ld) begin
			buf_q <= rd_vld_q ? rdata : '0;
		end
		if (c.step) begin
			case (mode_q)
				pfba_pkg::MD_SCAN: begin
					if (cur_bit) begin
						run_q <= '0;
					end else begin
						if (run_q == 11'd0) begin
							first_q <= cur_q;
							first_wa_q <= wa_q;
							first_bo_q <= bo_q;
						end
						run_q <= run_q + 11'd1;
					end
				end
				pfba_pkg::MD_WRITE: buf_q[bo_q] <= val_q;
				default: rbit_q <= cur_bit;
			endcase
			cur_q <= nxt;
			bo_q <= s.wrap ? '0 : bo_q + BW'(1);
			if (s.last) begin
				done_q <= 1'b1;
			end
			if (hit) begin
				found_q <= 1'b1;
			end
		end
		if (c.wb) begin
			wa_q <= wa_q + AW'(1);
		end
		if (c.finish) begin
			if (early_q) begin
				status <= est_q;
			end else if (cmd_q == pfba_pkg::CMD_ALLOC && !found_q) begin
				status <= pfba_pkg::ST_NO_RUN;
			end else begin
				status <= pfba_pkg::ST_OK;
			end
			start_page <= (!early_q && cmd_q == pfba_pkg::CMD_ALLOC && found_q) ?
				10'(first_q) : 10'd0;
			bit_value <= (!early_q && cmd_q == pfba_pkg::CMD_QUERY) ? rbit_q : 1'b0;
		end
	end

	pfba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk(clk),
		.we(c.wb && mode_q == pfba_pkg::MD_WRITE),
		.waddr(wa_q),
		.wdata(buf_q),
		.raddr(wa_q),
		.rdata(rdata)
	);

endmodule

// File: rtl/pfba_ctrl.sv
// sequencing state machine for the page frame allocator
module pfba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output pfba_pkg::dp_cmd_t   c,
	input  pfba_pkg::dp_stat_t  s
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SETUP = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_LD    = 3'd3;
	localparam logic [2:0] S_BIT   = 3'd4;
	localparam logic [2:0] S_WB    = 3'd5;
	localparam logic [2:0] S_MARK  = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;

	assign in_stall = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		c = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					c.take = 1'b1;
					state_d = S_SETUP;
				end
			end
			S_SETUP: begin
				c.setup = 1'b1;
				state_d = (s.early || s.empty) ? S_FIN : S_RD;
			end
			S_RD: begin
				c.rd = 1'b1;
				state_d = S_LD;
			end
			S_LD: begin
				c.ld = 1'b1;
				state_d = S_BIT;
			end
			S_BIT: begin
				c.step = 1'b1;
				if (s.last || s.wrap) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				c.wb = 1'b1;
				if (!s.done) begin
					state_d = S_RD;
				end else if (s.scan && s.found) begin
					state_d = S_MARK;
				end else begin
					state_d = S_FIN;
				end
			end
			S_MARK: begin
				c.mark_setup = 1'b1;
				state_d = S_RD;
			end
			S_FIN: begin
				// hold the result until the output register is free
				if (!out_valid_q || !out_stall) begin
					c.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (c.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/page_frame_bitmap_allocator.sv
// page frame bitmap allocator: one busy bit per page, first-fit contiguous alloc
//
// requests arrive on in_valid/in_stall with cmd, page_index, count and busy_req;
// each request yields one result on out_valid/out_stall (status, start_page,
// bit_value). a request is taken only while the block is idle, one at a time.
// the busy map sits in a ram of MAX_PAGES/WORD_BITS words; every command that is
// not rejected walks the affected pages one bit per cycle within a word, loading
// a word each time the walk reaches a new one and, for free, mark and init,
// writing it back once its bits are done. a rejected request or an empty range
// goes from setup straight to the result register. alloc scans from page 0 to
// the end of the fitting run (or to page_count if none fits) and then marks the
// run. the next request is taken in the cycle after the result is registered,
// so requests do not overlap. the result stays in an output register; while
// out_stall holds it, the block can still accept and work one more request,
// but finishes it only once the held result is taken.
// configuration writes (cfg_we, cfg_index, cfg_data) are for idle periods only.
// reset: every page free, page_count 1024, reserved_pages 0, no result pending.
module page_frame_bitmap_allocator #(
	parameter int MAX_PAGES = 1024,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [19:0] page_index,
	input  logic [10:0] count,
	input  logic        busy_req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [9:0]  start_page,
	output logic        bit_value,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);

	pfba_pkg::dp_cmd_t  dp_cmd;
	pfba_pkg::dp_stat_t dp_stat;

	pfba_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.c(dp_cmd),
		.s(dp_stat)
	);

	pfba_datapath #(
		.MAX_PAGES(MAX_PAGES),
		.WORD_BITS(WORD_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.c(dp_cmd),
		.s(dp_stat),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.page_index(page_index),
		.count(count),
		.busy_req(busy_req),
		.status(status),
		.start_page(start_page),
		.bit_value(bit_value)
	);

endmodule

// File: sim/page_frame_bitmap_allocator_test.sv
// testbench for the page frame bitmap allocator: directed, config, random and backpressure
`timescale 1ns / 1ps

module page_frame_bitmap_allocator_test;

	localparam int PAGES = 1024;
	// codes the block does not define; they must answer ok with zero fields
	localparam logic [2:0] CMD_SPARE_5 = 3'd5;
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	typedef struct {
		logic [1:0] status;
		logic [9:0] start_page;
		logic       bit_value;
	} page_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  cmd = '0;
	logic [19:0] page_index = '0;
	logic [10:0] count = '0;
	logic        busy_req = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [9:0]  start_page;
	logic        bit_value;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [10:0] cfg_data = '0;

	// copy of the block's state as the predictor sees it
	logic [PAGES-1:0] busy_bits = '0;
	logic [10:0]      page_count_reg = 11'd1024;
	logic [10:0]      reserved_reg = 11'd0;

	page_result_t pending_results[$];
	int errors = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int allocs_granted = 0;
	int allocs_refused = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	page_frame_bitmap_allocator i_dut (.*);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// apply one request to the predicted map and return its answer
	function automatic page_result_t apply_request(logic [2:0] c, logic [19:0] idx,
			logic [10:0] cnt, logic req);
		page_result_t r;
		int pc, run, first, lim;
		longint stop;
		bit found;
		r.status = pfba_pkg::ST_OK;
		r.start_page = '0;
		r.bit_value = 1'b0;
		pc = (page_count_reg > PAGES) ? PAGES : page_count_reg;
		case (c)
			pfba_pkg::CMD_ALLOC: begin
				if (cnt == 0) begin
					r.status = pfba_pkg::ST_ZERO;
				end else begin
					run = 0;
					first = 0;
					found = 1'b0;
					for (int i = 0; i < pc; i++) begin
						if (busy_bits[i]) begin
							run = 0;
						end else begin
							if (run == 0)
								first = i;
							run++;
							if (run == cnt) begin
								found = 1'b1;
								break;
							end
						end
					end
					if (!found) begin
						r.status = pfba_pkg::ST_NO_RUN;
						allocs_refused++;
					end else begin
						for (int i = first; i < first + cnt; i++)
							busy_bits[i] = 1'b1;
						r.start_page = first[9:0];
						allocs_granted++;
					end
				end
			end
			pfba_pkg::CMD_FREE: begin
				if (cnt == 0) begin
					r.status = pfba_pkg::ST_ZERO;
				end else if (idx >= pc) begin
					r.status = pfba_pkg::ST_RANGE;
				end else begin
					stop = longint'(idx) + cnt;
					if (stop > pc)
						stop = pc;
					for (int i = idx; i < stop; i++)
						busy_bits[i] = 1'b0;
				end
			end
			pfba_pkg::CMD_MARK: begin
				if (idx >= pc)
					r.status = pfba_pkg::ST_RANGE;
				else
					busy_bits[idx] = req;
			end
			pfba_pkg::CMD_QUERY: begin
				if (idx >= pc)
					r.status = pfba_pkg::ST_RANGE;
				else
					r.bit_value = busy_bits[idx];
			end
			pfba_pkg::CMD_INIT: begin
				lim = (reserved_reg < pc) ? reserved_reg : pc;
				busy_bits = '0;
				for (int i = 0; i < lim; i++)
					busy_bits[i] = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	// offer one request; returns at the edge where it was taken, valid left high
	task automatic send_request(logic [2:0] c, logic [19:0] idx, logic [10:0] cnt,
			logic req);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		page_index <= idx;
		count <= cnt;
		busy_req <= req;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(apply_request(c, idx, cnt, req));
		requests_sent++;
	endtask

	// drop valid and wait until every answer is back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [10:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == pfba_pkg::CFG_PAGE_COUNT)
			page_count_reg = value;
		else
			reserved_reg = value;
	endtask

	task automatic test_directed();
		send_request(pfba_pkg::CMD_QUERY, 20'd0, 11'd0, 1'b0);
		send_request(pfba_pkg::CMD_MARK, 20'd0, 11'd0, 1'b1);
		send_request(pfba_pkg::CMD_QUERY, 20'd0, 11'd0, 1'b0);
		send_request(pfba_pkg::CMD_MARK, 20'd1023, 11'd0, 1'b1);
		send_request(pfba_pkg::CMD_QUERY, 20'd1023, 11'd0, 1'b1);
		send_request(pfba_pkg::CMD_ALLOC, 20'd0, 11'd0, 1'b0);
		send_request(pfba_pkg::CMD_FREE, 20'd5, 11'd0, 1'b0);
		send_request(pfba_pkg::CMD_FREE, 20'hFFFFF, 11'd0, 1'b0);
		send_request(pfba_pkg::CMD_FREE, 20'd1024, 11'd3, 1'b0);
		send_request(pfba_pkg::CMD_MARK, 20'hFFFFF, 11'd0, 1'b1);
		send_request(pfba_pkg::CMD_QUERY, 20'd1024, 11'd0, 1'b0);
		send_request(pfba_pkg::CMD_ALLOC, 20'd0, 11'd1, 1'b0);
		send_request(pfba_pkg::CMD_ALLOC, 20'd0, 11'd1024, 1'b0);
		send_request(pfba_pkg::CMD_ALLOC, 20'd0, 11'd2047, 1'b0);
		send_request(pfba_pkg::CMD_FREE, 20'd1020, 11'd2047, 1'b0);
		send_request(pfba_pkg::CMD_QUERY, 20'd1023, 11'd0, 1'b0);
		send_request(CMD_SPARE_5, 20'hFFFFF, 11'h7FF, 1'b1);
		send_request(CMD_SPARE_6, 20'd3, 11'd3, 1'b0);
		send_request(CMD_SPARE_7, 20'd0, 11'd1, 1'b1);
		send_request(pfba_pkg::CMD_INIT, 20'd0, 11'd0, 1'b0);
		send_request(pfba_pkg::CMD_ALLOC, 20'd0, 11'd1024, 1'b0);
		send_request(pfba_pkg::CMD_QUERY, 20'd511, 11'd0, 1'b0);
		send_request(pfba_pkg::CMD_FREE, 20'd0, 11'd1024, 1'b0);
	endtask

	task automatic test_config();
		// no managed pages at all
		write_reg(pfba_pkg::CFG_PAGE_COUNT, 11'd0);
		send_request(pfba_pkg::CMD_ALLOC, 20'd0, 11'd1, 1'b0);
		send_request(pfba_pkg::CMD_FREE, 20'd0, 11'd1, 1'b0);
		send_request(pfba_pkg::CMD_MARK, 20'd0, 11'd0, 1'b1);
		send_request(pfba_pkg::CMD_QUERY, 20'd0, 11'd0, 1'b0);
		send_request(pfba_pkg::CMD_INIT, 20'd0, 11'd0, 1'b0);
		// count above the maximum behaves as the maximum
		write_reg(pfba_pkg::CFG_PAGE_COUNT, 11'd2047);
		write_reg(pfba_pkg::CFG_RESERVED, 11'd2047);
		send_request(pfba_pkg::CMD_INIT, 20'd0, 11'd0, 1'b0);
		send_request(pfba_pkg::CMD_ALLOC, 20'd0, 11'd1, 1'b0);
		send_request(pfba_pkg::CMD_QUERY, 20'd1023, 11'd0, 1'b0);
		send_request(pfba_pkg::CMD_QUERY, 20'd1024, 11'd0, 1'b0);
		write_reg(pfba_pkg::CFG_PAGE_COUNT, 11'd1);
		write_reg(pfba_pkg::CFG_RESERVED, 11'd1);
		send_request(pfba_pkg::CMD_INIT, 20'd0, 11'd0, 1'b0);
		send_request(pfba_pkg::CMD_QUERY, 20'd0, 11'd0, 1'b0);
		send_request(pfba_pkg::CMD_ALLOC, 20'd0, 11'd1, 1'b0);
		send_request(pfba_pkg::CMD_FREE, 20'd0, 11'd5, 1'b0);
		send_request(pfba_pkg::CMD_ALLOC, 20'd0, 11'd1, 1'b0);
		send_request(pfba_pkg::CMD_ALLOC, 20'd0, 11'd2, 1'b0);
	endtask

	task automatic random_phase(int pages, int n);
		int r, pc;
		logic [2:0] c;
		logic [19:0] idx;
		logic [10:0] cnt;
		write_reg(pfba_pkg::CFG_PAGE_COUNT, pages[10:0]);
		write_reg(pfba_pkg::CFG_RESERVED, 11'($urandom_range(0, pages + 4)));
		pc = pages;
		send_request(pfba_pkg::CMD_INIT, '0, '0, 1'b0);
		quiet = 1'b0;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 20)
				quiet = ~quiet;
			r = $urandom_range(0, 99);
			if (r < 32)
				c = pfba_pkg::CMD_ALLOC;
			else if (r < 55)
				c = pfba_pkg::CMD_FREE;
			else if (r < 72)
				c = pfba_pkg::CMD_MARK;
			else if (r < 92)
				c = pfba_pkg::CMD_QUERY;
			else if (r < 95)
				c = pfba_pkg::CMD_INIT;
			else
				c = 3'($urandom_range(5, 7));
			r = $urandom_range(0, 99);
			if (r < 85)
				idx = 20'($urandom_range(0, pc + 1));
			else
				idx = 20'($urandom);
			r = $urandom_range(0, 99);
			if (r < 70)
				cnt = 11'($urandom_range(1, 8));
			else if (r < 78)
				cnt = '0;
			else if (r < 95)
				cnt = 11'($urandom_range(1, pc + 2));
			else
				cnt = 11'($urandom);
			send_request(c, idx, cnt, 1'($urandom));
		end
		quiet = 1'b0;
	endtask

	task automatic test_random();
		random_phase(40, 120);
		random_phase(96, 120);
		random_phase(17, 120);
		random_phase(64, 120);
		random_phase(1024, 60);
		random_phase(33, 110);
	endtask

	// hold the result side long enough that the block backs up
	task automatic test_backpressure();
		drain();
		hold_req = 1'b1;
		for (int k = 0; k < 12; k++)
			send_request(k % 2 ? pfba_pkg::CMD_QUERY : pfba_pkg::CMD_MARK, 20'(k),
				11'd1, 1'b1);
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 25) ||
				(($urandom_range(0, 99) < 3) && out_stall);
		end
	end

	always @(posedge clk) begin
		page_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, status);
					errors++;
				end
				if (start_page !== want.start_page) begin
					$error("start_page expected %0d actual %0d", want.start_page,
						start_page);
					errors++;
				end
				if (bit_value !== want.bit_value) begin
					$error("bit_value expected %0d actual %0d", want.bit_value,
						bit_value);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		test_directed();
		test_config();
		test_random();
		test_backpressure();
		drain();
		repeat (50) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			errors++;
		end
		$display("covered %0d requests, %0d results, %0d allocs granted, %0d refused",
			requests_sent, results_seen, allocs_granted, allocs_refused);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#100ms;
		$display("tb: failure");
		$finish;
	end

endmodule
